@@ rtl/nhe_pkg.sv @@
// Package for the normalized Hermite evaluator: payload types, formats and coefficient functions.
`timescale 1ns / 1ps
`default_nettype none

package nhe_pkg;

    localparam int MAX_DEGREE_DEF = 31;
    localparam int DEG_W          = 5;
    localparam int X_W            = 16;
    localparam int VAL_W          = 48;
    localparam int COEF_W         = 31;

    localparam logic signed [VAL_W-1:0] P0_Q24  = 48'sd12601796;
    localparam logic signed [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
    localparam logic signed [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};

    typedef struct packed {
        logic [DEG_W-1:0]        degree;
        logic signed [X_W-1:0]   abscissa;
    } nhe_in_t;

    typedef struct packed {
        logic signed [VAL_W-1:0] value;
        logic                    overflow;
    } nhe_out_t;

    // A(j) = floor(sqrt(2/j) * 2^30): the largest r with r*r*j <= 2^61.
    function automatic logic [COEF_W-1:0] coef_a(input int j);
        logic [127:0] r;
        logic [127:0] t;
        logic [127:0] jj;
        int           b;
        r  = '0;
        jj = 128'(j);
        for (b = COEF_W - 1; b >= 0; b--)
        begin
            t = r | (128'd1 << b);
            if (t * t * jj <= (128'd1 << 61))
            begin
                r = t;
            end
        end
        return r[COEF_W-1:0];
    endfunction

    // B(j) = floor(sqrt((j-1)/j) * 2^30): the largest r with 2^60 <= j*(2^60 - r*r).
    function automatic logic [COEF_W-2:0] coef_b(input int j);
        logic [127:0] r;
        logic [127:0] t;
        logic [127:0] jj;
        int           b;
        r  = '0;
        jj = 128'(j);
        for (b = COEF_W - 2; b >= 0; b--)
        begin
            t = r | (128'd1 << b);
            if ((128'd1 << 60) <= jj * ((128'd1 << 60) - t * t))
            begin
                r = t;
            end
        end
        return r[COEF_W-2:0];
    endfunction

endpackage

`default_nettype wire

@@ rtl/normalized_hermite_eval_unit.sv @@
// Normalized Hermite polynomial evaluator on one shared 32x32 multiplier.
//
//   Channel | Handshake                  | Payload
//   --------+----------------------------+-----------------------------------
//   input   | in_valid / in_ready        | in_item  (degree, abscissa Q3.12)
//   output  | out_valid / out_ready      | out_item (value Q23.24, overflow)
//
// A new item is taken only once the last one is finished and placed in the output register.
// Each recurrence step runs eleven phases: coefficient fetch, seven partial products on
// the shared multiplier, the last accumulation, rounding with saturation, and the update.
// The result waits in an output register; a full register holds the finished item.
// Reset is asynchronous and clears only the control state.
`timescale 1ns / 1ps
`default_nettype none

module normalized_hermite_eval_unit
    import nhe_pkg::*;
#(
    parameter int MAX_DEGREE = MAX_DEGREE_DEF
)
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     in_valid,
    output logic          in_ready,
    input  wire nhe_in_t  in_item,
    output logic          out_valid,
    input  wire logic     out_ready,
    output nhe_out_t      out_item
);

    localparam int CNT_W     = $clog2(MAX_DEGREE + 1);
    localparam int CMP_W     = (CNT_W > DEG_W) ? CNT_W : DEG_W;
    localparam int ROM_DEPTH = 1 << CNT_W;
    localparam int OP_W      = 32;
    localparam int PROD_W    = 2 * OP_W;
    localparam int C_W       = COEF_W + X_W;
    localparam int ACC_A_W   = C_W + VAL_W;
    localparam int ACC_B_W   = COEF_W - 1 + VAL_W;
    localparam int SH_A      = 42;
    localparam int SH_B      = 30;
    localparam int RA_W      = ACC_A_W + 1;
    localparam int RB_W      = ACC_B_W + 1;
    localparam int MA_W      = RA_W - SH_A;
    localparam int MB_W      = RB_W - SH_B;

    localparam logic [VAL_W-1:0] MAG_POS_LIM = {1'b0, {(VAL_W-1){1'b1}}};
    localparam logic [VAL_W-1:0] MAG_NEG_LIM = {1'b1, {(VAL_W-1){1'b0}}};

    localparam logic [3:0] PH_COEF   = 4'd0;
    localparam logic [3:0] PH_MUL_X  = 4'd1;
    localparam logic [3:0] PH_B_LO   = 4'd2;
    localparam logic [3:0] PH_B_HI   = 4'd3;
    localparam logic [3:0] PH_CL_QL  = 4'd4;
    localparam logic [3:0] PH_CL_QH  = 4'd5;
    localparam logic [3:0] PH_CH_QL  = 4'd6;
    localparam logic [3:0] PH_CH_QH  = 4'd7;
    localparam logic [3:0] PH_ACC    = 4'd8;
    localparam logic [3:0] PH_ROUND  = 4'd9;
    localparam logic [3:0] PH_UPDATE = 4'd10;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_RUN  = 2'b10
    } state_t;

    state_t                  state_reg, state_next;
    logic [3:0]              ph_reg, ph_next;
    logic [CNT_W-1:0]        k_reg, k_next;
    logic [CNT_W-1:0]        n_reg;
    logic                    out_valid_reg, out_valid_next;
    nhe_out_t                out_item_reg;

    logic                    x_neg_reg;
    logic [X_W-1:0]          xm_reg;
    logic [COEF_W-1:0]       a_reg;
    logic [COEF_W-2:0]       b_reg;
    logic [VAL_W-1:0]        pm_reg;
    logic [VAL_W-1:0]        qm_reg;
    logic signed [VAL_W-1:0] prev_reg;
    logic signed [VAL_W-1:0] cur_reg;
    logic [C_W-1:0]          c_reg;
    logic [PROD_W-1:0]       mul_reg;
    logic [ACC_A_W-1:0]      acc_a_reg;
    logic [ACC_B_W-1:0]      acc_b_reg;
    logic signed [VAL_W-1:0] t1_reg;
    logic signed [VAL_W-1:0] t2_reg;
    logic                    ov_reg;

    logic [COEF_W-1:0]       a_rom [ROM_DEPTH];
    logic [COEF_W-2:0]       b_rom [ROM_DEPTH];

    logic                    accept;
    logic                    finish;
    logic                    slot_free;
    logic                    load_out;
    logic [CNT_W-1:0]        j_idx;
    logic [CMP_W-1:0]        deg_ext;
    logic [CNT_W-1:0]        n_clamp;
    logic [X_W-1:0]          x_raw;
    logic [X_W-1:0]          x_mag;
    logic [VAL_W-1:0]        prev_mag;
    logic [VAL_W-1:0]        cur_mag;
    logic [OP_W-1:0]         mul_a;
    logic [OP_W-1:0]         mul_b;
    logic [PROD_W-1:0]       prod;
    logic                    neg1;
    logic                    neg2;
    logic [RA_W-1:0]         rnd_a;
    logic [RB_W-1:0]         rnd_b;
    logic [MA_W-1:0]         mag1;
    logic [MB_W-1:0]         mag2;
    logic [VAL_W-1:0]        lim1;
    logic [VAL_W-1:0]        lim2;
    logic                    ov1;
    logic                    ov2;
    logic [VAL_W-1:0]        sat1;
    logic [VAL_W-1:0]        sat2;
    logic [VAL_W-1:0]        t1_val;
    logic [VAL_W-1:0]        t2_val;
    logic signed [VAL_W:0]   diff;
    logic                    diff_ovf;
    logic signed [VAL_W-1:0] nxt;

    for (genvar g = 0; g < ROM_DEPTH; g++)
    begin : g_rom
        assign a_rom[g] = coef_a(g);
        assign b_rom[g] = coef_b(g);
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign accept    = in_valid && in_ready;
    assign slot_free = !out_valid_reg || out_ready;
    assign finish    = (state_reg == S_RUN) && (ph_reg == PH_COEF) && (k_reg == n_reg);
    assign load_out  = finish && slot_free;
    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;
    assign j_idx     = k_reg + CNT_W'(1);

    assign deg_ext = CMP_W'(in_item.degree);
    assign n_clamp = (deg_ext > CMP_W'(MAX_DEGREE)) ? CNT_W'(MAX_DEGREE) : CNT_W'(deg_ext);

    assign x_raw    = in_item.abscissa;
    assign x_mag    = x_raw[X_W-1] ? (~x_raw + X_W'(1)) : x_raw;
    assign prev_mag = prev_reg[VAL_W-1] ? (~prev_reg + VAL_W'(1)) : prev_reg;
    assign cur_mag  = cur_reg[VAL_W-1] ? (~cur_reg + VAL_W'(1)) : cur_reg;

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (ph_reg)
            PH_MUL_X:
            begin
                mul_a = OP_W'(a_reg);
                mul_b = OP_W'(xm_reg);
            end
            PH_B_LO:
            begin
                mul_a = OP_W'(b_reg);
                mul_b = pm_reg[OP_W-1:0];
            end
            PH_B_HI:
            begin
                mul_a = OP_W'(b_reg);
                mul_b = OP_W'(pm_reg[VAL_W-1:OP_W]);
            end
            PH_CL_QL:
            begin
                mul_a = c_reg[OP_W-1:0];
                mul_b = qm_reg[OP_W-1:0];
            end
            PH_CL_QH:
            begin
                mul_a = c_reg[OP_W-1:0];
                mul_b = OP_W'(qm_reg[VAL_W-1:OP_W]);
            end
            PH_CH_QL:
            begin
                mul_a = OP_W'(c_reg[C_W-1:OP_W]);
                mul_b = qm_reg[OP_W-1:0];
            end
            PH_CH_QH:
            begin
                mul_a = OP_W'(c_reg[C_W-1:OP_W]);
                mul_b = OP_W'(qm_reg[VAL_W-1:OP_W]);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod = PROD_W'(mul_a) * PROD_W'(mul_b);

    assign neg1   = x_neg_reg ^ cur_reg[VAL_W-1];
    assign neg2   = prev_reg[VAL_W-1];
    assign rnd_a  = RA_W'(acc_a_reg) + (RA_W'(1) << (SH_A - 1));
    assign rnd_b  = RB_W'(acc_b_reg) + (RB_W'(1) << (SH_B - 1));
    assign mag1   = rnd_a[RA_W-1:SH_A];
    assign mag2   = rnd_b[RB_W-1:SH_B];
    assign lim1   = neg1 ? MAG_NEG_LIM : MAG_POS_LIM;
    assign lim2   = neg2 ? MAG_NEG_LIM : MAG_POS_LIM;
    assign ov1    = mag1 > MA_W'(lim1);
    assign ov2    = mag2 > MB_W'(lim2);
    assign sat1   = ov1 ? lim1 : mag1[VAL_W-1:0];
    assign sat2   = ov2 ? lim2 : mag2[VAL_W-1:0];
    assign t1_val = neg1 ? (~sat1 + VAL_W'(1)) : sat1;
    assign t2_val = neg2 ? (~sat2 + VAL_W'(1)) : sat2;

    assign diff     = {t1_reg[VAL_W-1], t1_reg} - {t2_reg[VAL_W-1], t2_reg};
    assign diff_ovf = diff[VAL_W] ^ diff[VAL_W-1];
    assign nxt      = diff_ovf ? (diff[VAL_W] ? VAL_MIN : VAL_MAX) : diff[VAL_W-1:0];

    always_comb
    begin
        state_next     = state_reg;
        ph_next        = ph_reg;
        k_next         = k_reg;
        out_valid_next = out_valid_reg;
        if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        unique case (state_reg)
            S_IDLE:
            begin
                ph_next = PH_COEF;
                if (accept)
                begin
                    state_next = S_RUN;
                    k_next     = '0;
                end
            end
            S_RUN:
            begin
                if (ph_reg == PH_COEF)
                begin
                    if (load_out)
                    begin
                        state_next = S_IDLE;
                    end
                    else if (!finish)
                    begin
                        ph_next = PH_MUL_X;
                    end
                end
                else if (ph_reg == PH_UPDATE)
                begin
                    ph_next = PH_COEF;
                    k_next  = k_reg + CNT_W'(1);
                end
                else
                begin
                    ph_next = ph_reg + 4'd1;
                end
            end
            default:
            begin
                state_next = S_IDLE;
                ph_next    = PH_COEF;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            ph_reg        <= PH_COEF;
            k_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ph_reg        <= ph_next;
            k_reg         <= k_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mul_reg <= prod;
        if (accept)
        begin
            n_reg     <= n_clamp;
            x_neg_reg <= x_raw[X_W-1];
            xm_reg    <= x_mag;
            prev_reg  <= '0;
            cur_reg   <= P0_Q24;
            ov_reg    <= 1'b0;
        end
        if (load_out)
        begin
            out_item_reg.value    <= cur_reg;
            out_item_reg.overflow <= ov_reg;
        end
        if (state_reg == S_RUN)
        begin
            unique case (ph_reg)
                PH_COEF:
                begin
                    a_reg  <= a_rom[j_idx];
                    b_reg  <= b_rom[j_idx];
                    pm_reg <= prev_mag;
                    qm_reg <= cur_mag;
                end
                PH_B_LO:
                begin
                    c_reg <= mul_reg[C_W-1:0];
                end
                PH_B_HI:
                begin
                    acc_b_reg <= ACC_B_W'(mul_reg);
                end
                PH_CL_QL:
                begin
                    acc_b_reg <= acc_b_reg + (ACC_B_W'(mul_reg) << OP_W);
                end
                PH_CL_QH:
                begin
                    acc_a_reg <= ACC_A_W'(mul_reg);
                end
                PH_CH_QL, PH_CH_QH:
                begin
                    acc_a_reg <= acc_a_reg + (ACC_A_W'(mul_reg) << OP_W);
                end
                PH_ACC:
                begin
                    acc_a_reg <= acc_a_reg + (ACC_A_W'(mul_reg) << (2 * OP_W));
                end
                PH_ROUND:
                begin
                    t1_reg <= t1_val;
                    t2_reg <= t2_val;
                    if (ov1 || ov2)
                    begin
                        ov_reg <= 1'b1;
                    end
                end
                PH_UPDATE:
                begin
                    prev_reg <= cur_reg;
                    cur_reg  <= nxt;
                    if (diff_ovf)
                    begin
                        ov_reg <= 1'b1;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

`ifndef SYNTHESIS
    a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
        ph_reg <= PH_UPDATE)
        else $error("Phase counter left its schedule.");

    a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_RUN |-> k_reg <= n_reg)
        else $error("Step counter passed the target degree.");

    a_degree_clamp: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_RUN |-> n_reg <= CNT_W'(MAX_DEGREE))
        else $error("Target degree above the built maximum.");

    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> state_reg == S_IDLE && $past(state_reg == S_RUN))
        else $error("Result appeared without a finished item.");
`endif

endmodule

`default_nettype wire

@@ tb/normalized_hermite_eval_unit_test.sv @@
// Self-checking testbench for the normalized Hermite evaluator, with its own fixed-point predictor.
`timescale 1ns / 1ps

module normalized_hermite_eval_unit_test;
    import nhe_pkg::*;

    logic     clk;
    logic     rst_n;
    logic     in_valid;
    logic     in_ready;
    nhe_in_t  in_item;
    logic     out_valid;
    logic     out_ready;
    nhe_out_t out_item;

    nhe_out_t hermite_expected_q[$];
    int       gap_max = 8;
    int       hold_left = 0;
    int       failures = 0;
    int       items_sent = 0;
    int       results_checked = 0;
    int       saturated_results = 0;

    normalized_hermite_eval_unit dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    initial
    begin
        #30_000_000;
        $display("normalized_hermite_eval_unit regression: fail");
        $finish;
    end

    function automatic longint unsigned floor_sqrt(input longint unsigned v);
        longint unsigned r;
        longint unsigned t;
        int              b;
        r = 0;
        for (b = 31; b >= 0; b--)
        begin
            t = r | (64'd1 << b);
            if (t * t <= v)
            begin
                r = t;
            end
        end
        return r;
    endfunction

    // Signed a*b / 2^shift, rounded half away from zero and clamped to 48 bits.
    function automatic logic signed [VAL_W-1:0] round_scale(input longint a, input longint b,
                                                            input int shift, output bit clamped);
        longint unsigned ma;
        longint unsigned mb;
        logic [127:0]    prod;
        logic [127:0]    lim;
        logic [VAL_W-1:0] m;
        bit              neg;
        neg  = (a < 0) != (b < 0);
        ma   = (a < 0) ? -a : a;
        mb   = (b < 0) ? -b : b;
        prod = {64'd0, ma} * {64'd0, mb};
        prod = (prod + (128'd1 << (shift - 1))) >> shift;
        lim  = neg ? (128'd1 << 47) : ((128'd1 << 47) - 128'd1);
        clamped = 1'b0;
        if (prod > lim)
        begin
            clamped = 1'b1;
            prod    = lim;
        end
        m = prod[VAL_W-1:0];
        return neg ? -m : m;
    endfunction

    function automatic nhe_out_t hermite_predict(input nhe_in_t item);
        nhe_out_t        res;
        longint          x;
        longint          prev;
        longint          cur;
        longint          coef_x;
        longint          diff;
        longint          t1;
        longint          t2;
        longint unsigned a_coef;
        longint unsigned b_coef;
        longint unsigned jj;
        bit              s1;
        bit              s2;
        bit              ovf;
        int              n;
        int              j;
        x    = {{(64-X_W){item.abscissa[X_W-1]}}, item.abscissa};
        prev = 0;
        cur  = longint'(P0_Q24);
        ovf  = 1'b0;
        n    = int'(item.degree);
        if (n > MAX_DEGREE_DEF)
        begin
            n = MAX_DEGREE_DEF;
        end
        for (j = 1; j <= n; j++)
        begin
            jj     = 64'(j);
            a_coef = floor_sqrt((64'd1 << 61) / jj);
            b_coef = floor_sqrt((64'd1 << 60) - ((64'd1 << 60) + jj - 64'd1) / jj);
            coef_x = longint'(a_coef) * x;
            t1     = longint'(round_scale(coef_x, cur, 42, s1));
            t2     = longint'(round_scale(longint'(b_coef), prev, 30, s2));
            ovf    = ovf | s1 | s2;
            diff   = t1 - t2;
            if (diff > VAL_MAX)
            begin
                diff = longint'(VAL_MAX);
                ovf  = 1'b1;
            end
            else if (diff < VAL_MIN)
            begin
                diff = longint'(VAL_MIN);
                ovf  = 1'b1;
            end
            prev = cur;
            cur  = diff;
        end
        res.value    = cur[VAL_W-1:0];
        res.overflow = ovf;
        return res;
    endfunction

    task automatic send_item(input logic [DEG_W-1:0] degree, input logic signed [X_W-1:0] x);
        nhe_in_t item;
        int      gap;
        item.degree   = degree;
        item.abscissa = x;
        gap = $urandom_range(0, gap_max);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= item;
        do
            @(posedge clk);
        while (!in_ready);
        hermite_expected_q.push_back(hermite_predict(item));
        items_sent++;
    endtask

    task automatic wait_all_results();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (hermite_expected_q.size() != 0);
    endtask

    function automatic logic signed [X_W-1:0] random_abscissa();
        case ($urandom_range(0, 3))
            0: return X_W'($urandom);
            1: return X_W'($urandom_range(0, 32767) - 16384);
            2: return X_W'($urandom_range(0, 255) - 128);
            default:
            begin
                if ($urandom_range(0, 1))
                begin
                    return X_W'(16'sh7FFF - $urandom_range(0, 15));
                end
                return X_W'(16'sh8000 + $urandom_range(0, 15));
            end
        endcase
    endfunction

    task automatic test_degree_zero();
        send_item(0, 16'sh0000);
        send_item(0, 16'sh7FFF);
        send_item(0, 16'sh8000);
        send_item(0, random_abscissa());
        wait_all_results();
    endtask

    task automatic test_low_degrees();
        send_item(1, 16'sh7FFF);
        send_item(1, 16'sh8000);
        send_item(2, 16'sh7FFF);
        send_item(2, 16'sh8000);
        send_item(2, 16'sh0001);
        send_item(2, 16'shFFFF);
        wait_all_results();
    endtask

    task automatic test_zero_abscissa();
        send_item(1, 16'sh0000);
        send_item(2, 16'sh0000);
        send_item(30, 16'sh0000);
        send_item(31, 16'sh0000);
        wait_all_results();
    endtask

    task automatic test_saturation();
        send_item(31, 16'sh7FFF);
        send_item(31, 16'sh8000);
        send_item(20, 16'sh7FFF);
        send_item(31, 16'sh1000);
        wait_all_results();
    endtask

    task automatic test_random_sweep();
        int i;
        for (i = 0; i < 650; i++)
        begin
            if (i % 200 == 199)
            begin
                wait_all_results();
            end
            case ((i / 130) % 4)
                0: gap_max = 8;
                1: gap_max = 2;
                2: gap_max = 0;
                default: gap_max = 8;
            endcase
            send_item(DEG_W'($urandom_range(0, 31)), random_abscissa());
        end
        gap_max = 8;
        wait_all_results();
    endtask

    task automatic test_back_to_back();
        int i;
        gap_max = 0;
        for (i = 0; i < 100; i++)
        begin
            send_item(DEG_W'($urandom_range(0, 31)), random_abscissa());
        end
        wait_all_results();
        gap_max = 8;
    endtask

    task automatic test_output_stall();
        int i;
        gap_max   = 0;
        hold_left = 2000;
        for (i = 0; i < 30; i++)
        begin
            send_item(DEG_W'($urandom_range(0, 3)), random_abscissa());
        end
        wait_all_results();
        gap_max = 8;
    endtask

    initial
    begin : result_monitor
        int       stall_left;
        nhe_out_t want;
        stall_left = 0;
        out_ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (out_valid && out_ready)
            begin
                if (hermite_expected_q.size() == 0)
                begin
                    failures++;
                    $display("%0t: unexpected result value=%0d overflow=%0b",
                             $time, $signed(out_item.value), out_item.overflow);
                end
                else
                begin
                    want = hermite_expected_q.pop_front();
                    results_checked++;
                    if (want.overflow)
                    begin
                        saturated_results++;
                    end
                    if (out_item.value !== want.value)
                    begin
                        failures++;
                        $display("%0t: value mismatch expected=%0d actual=%0d", $time,
                                 $signed(want.value), $signed(out_item.value));
                    end
                    if (out_item.overflow !== want.overflow)
                    begin
                        failures++;
                        $display("%0t: overflow mismatch expected=%0b actual=%0b", $time,
                                 want.overflow, out_item.overflow);
                    end
                end
                stall_left = $urandom_range(0, gap_max);
            end
            if (hold_left > 0)
            begin
                out_ready <= 1'b0;
                hold_left--;
            end
            else if (stall_left > 0)
            begin
                out_ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    initial
    begin
        rst_n    <= 1'b0;
        in_valid <= 1'b0;
        in_item  <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_degree_zero();
        test_low_degrees();
        test_zero_abscissa();
        test_saturation();
        test_random_sweep();
        test_back_to_back();
        test_output_stall();

        wait_all_results();
        repeat (400) @(posedge clk);

        $display("Checked %0d results for %0d transfers, %0d of them saturated.",
                 results_checked, items_sent, saturated_results);
        $display("Covered degrees 0 to 31 over the full abscissa range, %s",
                 "back-to-back traffic and a long output stall.");
        if (failures == 0)
        begin
            $display("normalized_hermite_eval_unit regression: pass");
        end
        else
        begin
            $display("normalized_hermite_eval_unit regression: fail");
        end
        $finish;
    end

endmodule
